// File: rtl/ole_pkg.sv
// ============================================================================
// ole_pkg: shared types and constants for the ordered list engine
// Command and status codes, controller states and the control and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package ole_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_READ_FWD   = 3'd6,
    CMD_READ_REV   = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // a command word is taken this cycle
    logic rd_start;  // the command is a read of a non-empty list
    logic rd_step;   // emit the next element of a read
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;      // the list holds no element
    logic rd_final;   // the element under the read pointer is the last one
    logic res_valid;  // the result register holds a word not yet taken
  } dp_stat_t;

endpackage

// File: rtl/ole_ctrl.sv
// ============================================================================
// ole_ctrl: command sequencer of the ordered list engine
// Takes command words while idle and the result register can accept a word, and
// steps the datapath through the elements of a read.
// ============================================================================
module ole_ctrl import ole_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  logic [CMD_W-1:0] command,
  input  logic             res_stall,
  input  dp_stat_t         stat,
  output ctl_cmd_t         ctl
);

  state_t state, state_next;
  logic   out_free;
  logic   is_read;

  // The result register can take a new word when empty or being drained.
  assign out_free = !stat.res_valid || !res_stall;
  assign is_read  = (command == CMD_READ_FWD) || (command == CMD_READ_REV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free && is_read && !stat.empty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (out_free && stat.rd_final) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall    = 1'b1;
    ctl.exec     = 1'b0;
    ctl.rd_start = 1'b0;
    ctl.rd_step  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_stall    = !out_free;
        ctl.exec     = cmd_valid && out_free;
        ctl.rd_start = cmd_valid && out_free && is_read && !stat.empty;
      end
      S_READ: begin
        ctl.rd_step = out_free;
      end
      default: cmd_stall = 1'b1;
    endcase
  end

endmodule

// File: rtl/ole_dpath.sv
// ============================================================================
// ole_dpath: element store, length and result register of the list engine
// Shifts the store in parallel on inserts and front removals and reads one
// element a cycle for the read commands while the result register can take a word.
// ============================================================================
module ole_dpath import ole_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_cmd_t                ctl,
  output dp_stat_t                stat,
  input  logic [CMD_W-1:0]        command,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  input  logic                    res_stall,
  output logic                    res_valid,
  output logic [STAT_W-1:0]       status,
  output logic [CNT_W-1:0]        count,
  output logic signed [VAL_W-1:0] element,
  output logic                    element_valid,
  output logic                    last
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic signed [VAL_W-1:0] store [DEPTH];
  logic [CNT_W-1:0]        length, length_next;
  logic                    full, empty;
  logic                    is_read, load_op;
  logic                    do_ins, do_popf;
  logic [CNT_W-1:0]        ins_idx;
  status_t                 op_status;
  logic [CMP_W-1:0]        pos_c, lim_c;

  logic                    rd_rev;
  logic [IDX_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        rd_src;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_final;

  assign full    = (length == CNT_W'(DEPTH));
  assign empty   = (length == '0);
  assign is_read = (command == CMD_READ_FWD) || (command == CMD_READ_REV);
  assign load_op = ctl.exec && !(is_read && !empty);
  assign pos_c   = CMP_W'(position);
  assign lim_c   = CMP_W'(length) + CMP_W'(1);

  always_comb begin
    do_ins      = 1'b0;
    do_popf     = 1'b0;
    ins_idx     = '0;
    op_status   = ST_OK;
    length_next = length;
    if (ctl.exec) begin
      unique case (cmd_t'(command))
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            op_status = ST_FULL;
          end else begin
            do_ins  = 1'b1;
            ins_idx = (command == CMD_PUSH_FRONT) ? '0 : length;
          end
        end
        CMD_INSERT: begin
          if (pos_c > lim_c) begin
            op_status = ST_BADPOS;
          end else if (full) begin
            op_status = ST_FULL;
          end else if (empty) begin
            do_ins = 1'b1;
          end else begin
            do_ins = 1'b1;
            if (position <= POS_W'(1)) begin
              ins_idx = CNT_W'(1);
            end else if (pos_c > CMP_W'(length)) begin
              ins_idx = length;
            end else begin
              ins_idx = CNT_W'(position);
            end
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            op_status = ST_EMPTY;
          end else begin
            do_popf     = 1'b1;
            length_next = length - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            op_status = ST_EMPTY;
          end else begin
            length_next = length - CNT_W'(1);
          end
        end
        CMD_READ_FWD, CMD_READ_REV: begin
          if (empty) begin
            op_status = ST_EMPTY;
          end
        end
        CMD_COUNT: begin
          op_status = ST_OK;
        end
        default: op_status = ST_OK;
      endcase
      if (do_ins) begin
        length_next = length + CNT_W'(1);
      end
    end
  end

  // Each entry takes its neighbour, the new value or holds.
  for (genvar j = 0; j < DEPTH; j++) begin : g_entry
    always_ff @(posedge clk) begin
      if (do_ins && (CNT_W'(j) == ins_idx)) begin
        store[j] <= value;
      end else if (do_ins && (CNT_W'(j) > ins_idx)) begin
        if (j > 0) begin
          store[j] <= store[(j > 0) ? j - 1 : 0];
        end
      end else if (do_popf && (j < DEPTH - 1)) begin
        store[j] <= store[(j < DEPTH - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else begin
      length <= length_next;
    end
  end

  // Read pointer: counts elements emitted, direction chosen at the start.
  always_ff @(posedge clk) begin
    if (ctl.rd_start) begin
      rd_ptr <= '0;
      rd_rev <= (command == CMD_READ_REV);
    end else if (ctl.rd_step) begin
      rd_ptr <= rd_ptr + IDX_W'(1);
    end
  end

  assign rd_final = ((CNT_W'(rd_ptr) + CNT_W'(1)) == length);
  assign rd_src   = rd_rev ? (length - CNT_W'(1) - CNT_W'(rd_ptr)) : CNT_W'(rd_ptr);
  assign rd_idx   = rd_src[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_op || ctl.rd_step) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_op) begin
      status        <= op_status;
      count         <= length_next;
      element       <= '0;
      element_valid <= 1'b0;
      last          <= 1'b1;
    end else if (ctl.rd_step) begin
      status        <= ST_OK;
      count         <= length;
      element       <= store[rd_idx];
      element_valid <= 1'b1;
      last          <= rd_final;
    end
  end

  assign stat.empty     = empty;
  assign stat.rd_final  = rd_final;
  assign stat.res_valid = res_valid;

endmodule

// File: rtl/ordered_list_engine.sv
// ============================================================================
// ordered_list_engine: ordered list of signed words with deque operations
// Keeps up to DEPTH words in order, takes pushes, positional inserts and
// removals, and streams its contents forward or in reverse.
// ============================================================================
//
//  Channel  | Handshake            | Payload                                | Words
//  ---------+----------------------+----------------------------------------+---------------
//  command  | cmd_valid, cmd_stall | command, value, position               | one per op
//  result   | res_valid, res_stall | status, count, element, element_valid, | 1, or 1..DEPTH
//           |                      | last                                   | for reads
//
// Flow: the result word of an update or count command is registered on the next
// edge, so such commands can follow one another every cycle while the result
// register can take a word. A read of a non-empty list is started by its command
// word and then emits its elements one at a time through the single read port on the element store; the
// next command word is taken after the last element has been registered.
// Reset: synchronous and active high; it empties the list and the result
// register. The element store itself is not cleared, as only entries below
// the length are ever read.
// Stalls: a held result word stalls the command channel and freezes a read.
//
module ordered_list_engine import ole_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  logic [CMD_W-1:0]        command,
  input  logic signed [VAL_W-1:0] value,
  input  logic [POS_W-1:0]        position,
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic [STAT_W-1:0]       status,
  output logic [CNT_W-1:0]        count,
  output logic signed [VAL_W-1:0] element,
  output logic                    element_valid,
  output logic                    last
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // The controller decides when a command word is taken and paces reads.
  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .res_stall (res_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath holds the list, its length and the result register.
  ole_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .command       (command),
    .value         (value),
    .position      (position),
    .res_stall     (res_stall),
    .res_valid     (res_valid),
    .status        (status),
    .count         (count),
    .element       (element),
    .element_valid (element_valid),
    .last          (last)
  );

endmodule

// File: rtl/ole_checker.sv
// ============================================================================
// ole_checker: port-level checks for the ordered list engine
// Watches the result channel of the top level over time.
// ============================================================================
module ole_checker import ole_pkg::*; #(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    res_valid,
  input logic                    res_stall,
  input logic [STAT_W-1:0]       status,
  input logic [CNT_W-1:0]        count,
  input logic signed [VAL_W-1:0] element,
  input logic                    element_valid,
  input logic                    last
);

  // Reset leaves no result word pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word pending after reset");

  // The reported count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (count <= CNT_W'(DEPTH)))
    else $error("count above depth");

  // Only read words may be non-final, and they carry an element with status ok.
  a_stream_word: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (!last || element_valid)) |-> (element_valid && status == ST_OK))
    else $error("malformed read word");

  // A word without an element carries zero and is final.
  a_zero_element: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !element_valid) |-> (element == '0 && last))
    else $error("non-read word carries an element");

  // A stalled result word stays valid and holds its element and last flag.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(element) && $stable(last)))
    else $error("stalled result word changed");

endmodule

bind ordered_list_engine ole_checker #(
  .DEPTH (DEPTH)
) u_ole_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .status        (status),
  .count         (count),
  .element       (element),
  .element_valid (element_valid),
  .last          (last)
);
